FILE: rtl/core/assert_macros.svh
// Shared assertion macros. Each expects clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define BSRB_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsrb check failed");

// Antecedent of two parts on successive cycles, consequent in the cycle after its second part.
`define BSRB_CHECK_SEQ(label, first, second, cons) \
  label: assert property (@(posedge clk) disable iff (rst) \
    (first) ##1 (second) |=> (cons)) \
    else $error("bsrb check failed");

`endif

FILE: rtl/core/bsrb_pkg.sv
`timescale 1ns / 1ps

package bsrb_pkg;

  localparam int CLK_W     = 32;
  localparam int RATE_W    = 18;
  localparam int MCLK_W    = 27;
  localparam int CFG_W     = 27;
  localparam int PROD_W    = CLK_W + RATE_W;
  localparam int REM_W     = MCLK_W + 1;
  localparam int ITER_W    = 6;
  localparam int ENABLE_BIT = 2;

  localparam logic [7:0]        LEVEL_ON        = 8'd255;
  localparam logic [RATE_W-1:0] RATE_RESET      = 18'd44100;
  localparam logic [MCLK_W-1:0] MCLK_RESET      = 27'd2048000;
  localparam logic [ITER_W-1:0] ITER_QUOTIENT   = 6'd50;
  localparam logic [ITER_W-1:0] ITER_ADVANCE    = 6'd28;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_SYNC  = 2'd2
  } command_t;

  typedef enum logic {
    REG_SAMPLE_RATE   = 1'b0,
    REG_MACHINE_CLOCK = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    command_t          command;
    logic [CLK_W-1:0]  clock_now;
    logic [7:0]        speaker_data;
    logic              block_start;
  } in_word_t;

  typedef struct packed {
    logic [7:0] sample;
    logic       underrun;
  } out_word_t;

endpackage

FILE: rtl/core/bsrb_stream_if.sv
`timescale 1ns / 1ps

interface bsrb_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/beeper_to_sample_ring_buffer_core.sv
`timescale 1ns / 1ps
// Sync and unused codes finish at accept; a read without block start reads the ring at accept
// and registers its result in ST_RD_DATA. Write: multiply, 50 + 28 bit-serial divide steps,
// check, mark update, N fills via the one ring write port (N <= RING_DEPTH), wrap-up; with no
// sample due the check goes to wrap-up, with a zero rate or clock the multiply does. A block-start
// read runs these steps too, then registers its result in ST_RD_DATA. Reads also wait for a free
// output slot. Synchronous reset clears pointers, mark and held values, loads register defaults.
module beeper_to_sample_ring_buffer_core #(
  parameter int RING_DEPTH = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [bsrb_pkg::CFG_W-1:0]   cfg_data,
  bsrb_stream_if.sink                  in_ch,
  bsrb_stream_if.source                out_ch
);

  localparam int PW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int PAD_W = bsrb_pkg::PROD_W - bsrb_pkg::REM_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_QCHK, ST_ADV, ST_MARK, ST_FILL, ST_POST, ST_RD_DATA
  } state_t;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    if (p == PW'(RING_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  state_t                          state;
  logic [bsrb_pkg::RATE_W-1:0]     sample_rate;
  logic [bsrb_pkg::MCLK_W-1:0]     machine_clock_hz;
  logic [PW-1:0]                   read_pointer;
  logic [PW-1:0]                   write_pointer;
  logic [bsrb_pkg::CLK_W-1:0]      clock_mark;
  logic [7:0]                      held_speaker;
  logic [7:0]                      held_sample;

  bsrb_pkg::command_t              cmd_q;
  logic [bsrb_pkg::CLK_W-1:0]      now_q;
  logic [7:0]                      data_q;
  logic [bsrb_pkg::PROD_W-1:0]     num;
  logic [bsrb_pkg::REM_W-1:0]      rem;
  logic [bsrb_pkg::ITER_W-1:0]     iter;
  logic [CW-1:0]                   fill_cnt;
  logic                            empty_q;
  bsrb_pkg::out_word_t             out_word;
  logic                            out_valid;

  logic [7:0]                      sample_ring [RING_DEPTH];
  logic [7:0]                      ram_q;

  logic                            in_acc;
  logic                            out_free;
  logic                            issue_read;
  logic                            ring_empty;
  logic                            ram_re;
  logic                            ram_we;
  logic [7:0]                      level;
  logic [bsrb_pkg::MCLK_W-1:0]     divisor;
  logic [bsrb_pkg::REM_W-1:0]      rem_sh;
  logic                            div_ge;
  logic [bsrb_pkg::REM_W-1:0]      adv_num;
  logic [PW-1:0]                   wr_ptr_next;
  logic [bsrb_pkg::CLK_W-1:0]      delta;

  assign in_ch.ready    = (state == ST_IDLE);
  assign in_acc         = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_word;
  assign out_free       = !out_valid || out_ch.ready;

  assign ring_empty = (read_pointer == write_pointer);
  assign issue_read = (state == ST_IDLE && in_acc &&
                       in_ch.payload.command == bsrb_pkg::CMD_READ &&
                       !in_ch.payload.block_start) ||
                      (state == ST_POST && cmd_q == bsrb_pkg::CMD_READ);
  assign ram_re      = issue_read && !ring_empty;
  assign ram_we      = (state == ST_FILL);
  assign level       = held_speaker[bsrb_pkg::ENABLE_BIT] ? bsrb_pkg::LEVEL_ON : 8'd0;
  assign wr_ptr_next = ring_next(write_pointer);
  // The clock difference wraps at 32 bits before it is widened for the multiply.
  assign delta       = now_q - clock_mark;

  // One restoring divide step per cycle; the quotient shifts into the low end of num.
  assign divisor = (state == ST_ADV) ? bsrb_pkg::MCLK_W'(sample_rate) : machine_clock_hz;
  assign rem_sh  = {rem[bsrb_pkg::REM_W-2:0], num[bsrb_pkg::PROD_W-1]};
  assign div_ge  = (rem_sh >= {1'b0, divisor});
  // Whole sample periods: advance = delta - ceil(remainder / sample_rate).
  assign adv_num = rem + bsrb_pkg::REM_W'(sample_rate) - bsrb_pkg::REM_W'(1);

  always_ff @(posedge clk) begin
    if (ram_we) begin
      sample_ring[write_pointer] <= level;
    end
    if (ram_re) begin
      ram_q <= sample_ring[read_pointer];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate      <= bsrb_pkg::RATE_RESET;
      machine_clock_hz <= bsrb_pkg::MCLK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bsrb_pkg::REG_SAMPLE_RATE:   sample_rate      <= cfg_data[bsrb_pkg::RATE_W-1:0];
        bsrb_pkg::REG_MACHINE_CLOCK: machine_clock_hz <= cfg_data[bsrb_pkg::MCLK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      read_pointer  <= '0;
      write_pointer <= '0;
      clock_mark    <= '0;
      held_speaker  <= '0;
      held_sample   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && state != ST_RD_DATA) begin
        out_valid <= 1'b0;
      end
      if (issue_read) begin
        empty_q <= ring_empty;
        if (!ring_empty) begin
          read_pointer <= ring_next(read_pointer);
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            cmd_q  <= in_ch.payload.command;
            now_q  <= in_ch.payload.clock_now;
            data_q <= in_ch.payload.speaker_data;
            case (in_ch.payload.command)
              bsrb_pkg::CMD_WRITE: state <= ST_MUL;
              bsrb_pkg::CMD_READ:  state <= in_ch.payload.block_start ? ST_MUL : ST_RD_DATA;
              bsrb_pkg::CMD_SYNC: begin
                clock_mark   <= in_ch.payload.clock_now;
                read_pointer <= write_pointer;
              end
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          if (machine_clock_hz == '0 || sample_rate == '0) begin
            state <= ST_POST;
          end else begin
            num   <= bsrb_pkg::PROD_W'(delta) * bsrb_pkg::PROD_W'(sample_rate);
            rem   <= '0;
            iter  <= bsrb_pkg::ITER_QUOTIENT;
            state <= ST_DIV;
          end
        end
        ST_DIV, ST_ADV: begin
          rem  <= div_ge ? rem_sh - {1'b0, divisor} : rem_sh;
          num  <= {num[bsrb_pkg::PROD_W-2:0], div_ge};
          iter <= iter - 1'b1;
          if (iter == bsrb_pkg::ITER_W'(1)) begin
            state <= (state == ST_DIV) ? ST_QCHK : ST_MARK;
          end
        end
        ST_QCHK: begin
          if (num == '0) begin
            state <= ST_POST;
          end else begin
            // Writing more than a full ring leaves the same readable samples.
            fill_cnt <= (num > bsrb_pkg::PROD_W'(RING_DEPTH)) ? CW'(RING_DEPTH)
                                                               : num[CW-1:0];
            num   <= {adv_num, PAD_W'(0)};
            rem   <= '0;
            iter  <= bsrb_pkg::ITER_ADVANCE;
            state <= ST_ADV;
          end
        end
        ST_MARK: begin
          clock_mark <= now_q - bsrb_pkg::CLK_W'(num[bsrb_pkg::REM_W-1:0]);
          state      <= ST_FILL;
        end
        ST_FILL: begin
          write_pointer <= wr_ptr_next;
          if (wr_ptr_next == read_pointer) begin
            read_pointer <= ring_next(read_pointer);
          end
          fill_cnt <= fill_cnt - 1'b1;
          if (fill_cnt == CW'(1)) begin
            state <= ST_POST;
          end
        end
        ST_POST: begin
          if (cmd_q == bsrb_pkg::CMD_WRITE) begin
            held_speaker <= data_q;
            state        <= ST_IDLE;
          end else begin
            held_sample <= '0;
            state       <= ST_RD_DATA;
          end
        end
        ST_RD_DATA: begin
          if (out_free) begin
            out_word.sample   <= empty_q ? held_sample : ram_q;
            out_word.underrun <= empty_q;
            out_valid         <= 1'b1;
            if (!empty_q) begin
              held_sample <= ram_q;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/bsrb_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsrb_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_command,
  input logic       in_block_start,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_sample,
  input logic       out_underrun
);

  logic in_acc;
  logic plain_read;

  assign in_acc     = in_valid && in_ready;
  assign plain_read = in_acc && in_command == bsrb_pkg::CMD_READ && !in_block_start;

  `BSRB_CHECK_NEXT(a_out_valid_holds, out_valid && !out_ready, out_valid)
  `BSRB_CHECK_NEXT(a_out_word_holds, out_valid && !out_ready,
    $stable(out_sample) && $stable(out_underrun))
  // A word that starts work blocks the input until that work is done.
  `BSRB_CHECK_NEXT(a_busy_after_work, in_acc && (in_command == bsrb_pkg::CMD_WRITE ||
    in_command == bsrb_pkg::CMD_READ), !in_ready)
  `BSRB_CHECK_NEXT(a_sync_one_cycle, in_acc && in_command == bsrb_pkg::CMD_SYNC, in_ready)
  // A read without block start delivers its word as soon as the output slot frees.
  `BSRB_CHECK_SEQ(a_plain_read_latency, plain_read, !out_valid || out_ready, out_valid)

endmodule

bind beeper_to_sample_ring_buffer_core bsrb_checker u_bsrb_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_command     (in_ch.payload.command),
  .in_block_start (in_ch.payload.block_start),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_sample     (out_ch.payload.sample),
  .out_underrun   (out_ch.payload.underrun)
);
